>>> hdl/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

  localparam int unsigned NumSlotsDefault = 8;

  localparam int unsigned ActionW   = 2;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned IdW       = 8;
  localparam int unsigned DurationW = 15;
  localparam int unsigned TickW     = 16;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK       = 2'd0,
    ACT_SCHEDULE   = 2'd1,
    ACT_UNSCHEDULE = 2'd2,
    ACT_PROCESS    = 2'd3
  } action_e;

  // command broadcast from the top level to every cell
  typedef struct packed {
    logic                 fire;
    action_e              action;
    logic [SlotW-1:0]     slot;
    logic [IdW-1:0]       timer_id;
    logic [DurationW-1:0] duration;
    logic                 periodic;
    logic [TickW-1:0]     tick;
  } cmd_t;

  // priority chain handed from cell to cell, lowest slot first
  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot;
    logic [IdW-1:0]   timer_id;
  } chain_t;

endpackage

`default_nettype wire

>>> hdl/ptt_in_if.sv
`default_nettype none

interface ptt_in_if;
  import ptt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ActionW-1:0]   action;
  logic [SlotW-1:0]     slot;
  logic [IdW-1:0]       timer_id;
  logic [DurationW-1:0] duration;
  logic                 periodic;

  modport source (output valid, action, slot, timer_id, duration, periodic, input ready);
  modport sink   (input valid, action, slot, timer_id, duration, periodic, output ready);
endinterface

`default_nettype wire

>>> hdl/ptt_out_if.sv
`default_nettype none

interface ptt_out_if;
  import ptt_pkg::*;

  logic             valid;
  logic             ready;
  logic             expired_found;
  logic [SlotW-1:0] expired_slot;
  logic [IdW-1:0]   expired_id;

  modport source (output valid, expired_found, expired_slot, expired_id, input ready);
  modport sink   (input valid, expired_found, expired_slot, expired_id, output ready);
endinterface

`default_nettype wire

>>> hdl/ptt_cell.sv
`default_nettype none

module ptt_cell
  import ptt_pkg::*;
#(
  parameter int unsigned CellIdx = 0
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  input  cmd_t   cmd_i,
  input  chain_t chain_i,
  output chain_t chain_o
);

  logic                 active_q, active_d;
  logic [TickW-1:0]     deadline_q, deadline_d;
  logic [DurationW-1:0] reload_q, reload_d;
  logic [IdW-1:0]       id_q, id_d;

  logic             addressed;
  logic [TickW-1:0] since;
  logic             hit;
  logic             take;

  assign addressed = (32'(cmd_i.slot) == 32'(CellIdx));
  assign since     = cmd_i.tick - deadline_q;
  assign hit       = active_q && !since[TickW-1];
  assign take      = cmd_i.fire && (cmd_i.action == ACT_PROCESS) && !chain_i.found && hit;

  always_comb begin
    if (!chain_i.found && hit) begin
      chain_o.found    = 1'b1;
      chain_o.slot     = SlotW'(CellIdx);
      chain_o.timer_id = id_q;
    end else begin
      chain_o = chain_i;
    end
  end

  always_comb begin
    active_d   = active_q;
    deadline_d = deadline_q;
    reload_d   = reload_q;
    id_d       = id_q;
    if (cmd_i.fire) begin
      unique case (cmd_i.action)
        ACT_SCHEDULE: begin
          if (addressed) begin
            active_d   = 1'b1;
            id_d       = cmd_i.timer_id;
            reload_d   = cmd_i.periodic ? cmd_i.duration : '0;
            deadline_d = cmd_i.tick + TickW'(cmd_i.duration);
          end
        end
        ACT_UNSCHEDULE: begin
          if (addressed) begin
            active_d = 1'b0;
          end
        end
        ACT_PROCESS: begin
          if (take) begin
            if (reload_q != '0) begin
              deadline_d = deadline_q + TickW'(reload_q);
            end else begin
              active_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
    reload_q   <= reload_d;
    id_q       <= id_d;
  end

endmodule

`default_nettype wire

>>> hdl/periodic_timer_table_unit.sv
// channel  | dir | payload                                       | handshake
// in_i     | in  | action, slot, timer_id, duration, periodic    | valid / ready
// out_o    | out | expired_found, expired_slot, expired_id       | valid / ready
//
// one beat per cycle unless out_o stalls: every beat in gives one beat out in the next cycle
// all cells compare their deadlines at once, a priority chain picks the lowest slot
// the output register takes a new result in the cycle its old one is taken
// reset clears the tick counter, the active flags and the output valid
// a stall on out_o holds in_i ready low until the waiting result is taken
`default_nettype none

module periodic_timer_table_unit
  import ptt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ptt_in_if.sink     in_i,
  ptt_out_if.source  out_o
);

  logic             fire;
  logic [TickW-1:0] tick_q, tick_d;
  cmd_t             cmd;
  chain_t           chain [NUM_SLOTS+1];

  logic             out_valid_q;
  logic             found_q, found_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [IdW-1:0]   id_q, id_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  assign cmd.fire     = fire;
  assign cmd.action   = action_e'(in_i.action);
  assign cmd.slot     = in_i.slot;
  assign cmd.timer_id = in_i.timer_id;
  assign cmd.duration = in_i.duration;
  assign cmd.periodic = in_i.periodic;
  assign cmd.tick     = tick_q;

  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    ptt_cell #(
      .CellIdx (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .chain_i (chain[g]),
      .chain_o (chain[g+1])
    );
  end

  assign tick_d = (fire && cmd.action == ACT_TICK) ? tick_q + TickW'(1) : tick_q;

  always_comb begin
    if (cmd.action == ACT_PROCESS && chain[NUM_SLOTS].found) begin
      found_d = 1'b1;
      slot_d  = chain[NUM_SLOTS].slot;
      id_d    = chain[NUM_SLOTS].timer_id;
    end else begin
      found_d = 1'b0;
      slot_d  = '0;
      id_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tick_q <= tick_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      found_q <= found_d;
      slot_q  <= slot_d;
      id_q    <= id_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.expired_found = found_q;
  assign out_o.expired_slot  = slot_q;
  assign out_o.expired_id    = id_q;

endmodule

`default_nettype wire

>>> hdl/ptt_checker.sv
`default_nettype none

module ptt_checker
  import ptt_pkg::*;
(
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_i,
  input wire [ActionW-1:0]   in_action_i,
  input wire                 out_valid_i,
  input wire                 out_ready_i,
  input wire                 out_found_i,
  input wire [SlotW-1:0]     out_slot_i,
  input wire [IdW-1:0]       out_id_i
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // every beat in gives a result beat on the next cycle
  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> out_valid_i)
    else $error("accepted beat produced no result");

  // only process can report an expired timer
  a_found_only_process: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_action_i != ACT_PROCESS) |=> !out_found_i)
    else $error("expired timer reported for non-process beat");

  // an empty result carries zero fields
  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> (out_slot_i == '0) && (out_id_i == '0))
    else $error("empty result with nonzero fields");

  // with no result waiting the input side is open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_found_i)
      && $stable(out_slot_i) && $stable(out_id_i))
    else $error("stalled result changed");

endmodule

bind periodic_timer_table_unit ptt_checker u_ptt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_found_i (out_o.expired_found),
  .out_slot_i  (out_o.expired_slot),
  .out_id_i    (out_o.expired_id)
);

`default_nettype wire
